FILE: rtl/tfli_pkg.sv
`default_nettype none
package tfli_pkg;

    localparam int STOPS_DEF   = 16;
    localparam int SAMPLES_DEF = 256;

    typedef enum logic [1:0] {
        MODE_APPEND_COLOR   = 2'd0,
        MODE_APPEND_OPACITY = 2'd1,
        MODE_EVALUATE       = 2'd2,
        MODE_CLEAR          = 2'd3
    } t_mode;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } t_div_ctl;

endpackage
`default_nettype wire

FILE: rtl/tfli_ram.sv
`default_nettype none
module tfli_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

FILE: rtl/tfli_div.sv
`default_nettype none
module tfli_div #(
    parameter int NW = 48,
    parameter int DW = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output logic               o_done,
    output logic      [NW-1:0] o_quot,
    output logic      [DW-1:0] o_rem
);

    localparam int CW = $clog2(NW + 1);

    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic [DW-1:0] r_den;
    logic [DW:0]   w_trial;
    logic [DW:0]   w_shift;

    assign w_shift = {o_rem, o_quot[NW-1]};
    assign w_trial = w_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            o_quot <= i_num;
            o_rem  <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            if (!w_trial[DW]) begin
                o_rem  <= w_trial[DW-1:0];
                o_quot <= {o_quot[NW-2:0], 1'b1};
            end else begin
                o_rem  <= w_shift[DW-1:0];
                o_quot <= {o_quot[NW-2:0], 1'b0};
            end
        end
    end

endmodule
`default_nettype wire

FILE: rtl/transfer_function_lut_interp_top.sv
// Channel  Direction  Handshake             Payload
// in       sink       i_valid / o_stall     mode, stop fields, sample index
// out      source     o_valid / i_stall     texel index, RGBA bytes
// Appends and clears may follow back to back.
// An evaluation walks each table through its memory read port, one stop at a time,
// then runs a bit-serial divider of 8+PW steps for each channel that it interpolates.
// Reset clears both stop counts; table contents stay unknown until written.
// A pending result holds while i_stall is high; o_stall is high while evaluating.
`default_nettype none
module transfer_function_lut_interp_top
    import tfli_pkg::*;
#(
    parameter int STOPS   = STOPS_DEF,
    parameter int SAMPLES = SAMPLES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_mode,
    input  wire logic [15:0] i_stop_position,
    input  wire logic [7:0]  i_stop_red,
    input  wire logic [7:0]  i_stop_green,
    input  wire logic [7:0]  i_stop_blue,
    input  wire logic [7:0]  i_stop_opacity,
    input  wire logic [7:0]  i_sample_index,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_texel_index,
    output logic [7:0]       o_red_out,
    output logic [7:0]       o_green_out,
    output logic [7:0]       o_blue_out,
    output logic [7:0]       o_alpha_out
);

    localparam int AW  = $clog2(STOPS);
    localparam int CW  = $clog2(STOPS + 1);
    localparam int SW  = $clog2(SAMPLES);
    localparam int PW  = ((SW > 8) ? 16 + SW : 24) + 1;
    localparam int NW  = 8 + PW;
    localparam int DW  = PW;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_READ  = 7'b0000010,
        S_WALK  = 7'b0000100,
        S_SPAN  = 7'b0001000,
        S_CHAN  = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state r_state;
    logic [CW-1:0] r_ccount, r_ocount;
    logic          r_tab;
    logic [AW-1:0] r_ptr;
    logic [AW-1:0] r_left;
    logic [1:0]    r_ch;
    logic [7:0]    r_idx;
    logic [PW-1:0] r_t;
    logic [15:0]   r_pl, r_pr;
    logic [23:0]   r_vl, r_vr;
    logic          r_beyond;
    logic [7:0]    r_res [4];
    logic [7:0]    r_vlc;
    logic          r_neg;

    logic          w_accept;
    logic          w_cwe, w_owe;
    logic [AW-1:0] w_raddr;
    logic [39:0]   w_crd;
    logic [23:0]   w_ord;
    logic [15:0]   w_rpos;
    logic [23:0]   w_rval;
    logic [CW-1:0] w_cnt;

    t_div_ctl      w_div;
    logic [NW-1:0] w_num, w_quot;
    logic [DW-1:0] w_den, w_rem;

    assign w_accept = i_valid && !o_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign w_cwe = w_accept && t_mode'(i_mode) == MODE_APPEND_COLOR && r_ccount < CW'(STOPS);
    assign w_owe = w_accept && t_mode'(i_mode) == MODE_APPEND_OPACITY && r_ocount < CW'(STOPS);

    tfli_ram #(.WIDTH(40), .DEPTH(STOPS)) u_cram (
        .i_clk(i_clk), .i_we(w_cwe), .i_waddr(r_ccount[AW-1:0]),
        .i_wdata({i_stop_position, i_stop_red, i_stop_green, i_stop_blue}),
        .i_raddr(w_raddr), .o_rdata(w_crd)
    );
    tfli_ram #(.WIDTH(24), .DEPTH(STOPS)) u_oram (
        .i_clk(i_clk), .i_we(w_owe), .i_waddr(r_ocount[AW-1:0]),
        .i_wdata({i_stop_position, i_stop_opacity}),
        .i_raddr(w_raddr), .o_rdata(w_ord)
    );

    assign w_rpos = r_tab ? w_ord[23:8] : w_crd[39:24];
    assign w_rval = r_tab ? {16'd0, w_ord[7:0]} : w_crd[23:0];
    assign w_cnt  = r_tab ? r_ocount : r_ccount;
    assign w_raddr = r_ptr;

    logic [PW-1:0] w_rpos_s;
    assign w_rpos_s = PW'(w_rpos) * PW'(SAMPLES);

    // Channel operands
    logic [7:0]        w_cvl, w_cvr;
    logic signed [9:0] w_dv;
    logic signed [PW:0] w_dt, w_dp;
    logic [7:0]        w_adv;
    logic [PW-1:0]     w_adt, w_adp;
    logic              w_sgn;
    always_comb begin
        case (r_ch)
            2'd0:    begin w_cvl = r_vl[23:16]; w_cvr = r_vr[23:16]; end
            2'd1:    begin w_cvl = r_vl[15:8];  w_cvr = r_vr[15:8];  end
            default: begin w_cvl = r_vl[7:0];   w_cvr = r_vr[7:0];   end
        endcase
        w_dv  = $signed({2'b0, w_cvr}) - $signed({2'b0, w_cvl});
        w_dt  = $signed({1'b0, r_t}) - $signed({1'b0, PW'(r_pl) * PW'(SAMPLES)});
        w_dp  = $signed({1'b0, PW'(r_pr) * PW'(SAMPLES)}) -
                $signed({1'b0, PW'(r_pl) * PW'(SAMPLES)});
        w_adv = w_dv[9] ? 8'(-w_dv) : w_dv[7:0];
        w_adt = w_dt[PW] ? PW'(-w_dt) : w_dt[PW-1:0];
        w_adp = w_dp[PW] ? PW'(-w_dp) : w_dp[PW-1:0];
        w_sgn = (w_dv[9] ^ w_dt[PW] ^ w_dp[PW]) && w_dv != 0 && w_dt != 0;
    end

    logic [NW-1:0] r_prod;
    assign w_num = r_prod;
    assign w_den = w_adp;
    assign w_div.busy = 1'b0;

    tfli_div #(.NW(NW), .DW(DW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div.start),
        .i_num(w_num), .i_den(w_den), .o_done(w_div.done),
        .o_quot(w_quot), .o_rem(w_rem)
    );

    // Floor of signed quotient, then add and clamp
    logic [NW:0]        w_q;
    logic signed [NW+1:0] w_v;
    logic [7:0]         w_clamp;
    always_comb begin
        w_q = {1'b0, w_quot} + ((r_neg && w_rem != '0) ? (NW+1)'(1) : '0);
        w_v = r_neg ? $signed({2'b0, NW'(r_vlc)}) - $signed({1'b0, w_q})
                    : $signed({2'b0, NW'(r_vlc)}) + $signed({1'b0, w_q});
        if (w_v < 0)                 w_clamp = 8'd0;
        else if (w_v > 255)          w_clamp = 8'd255;
        else                         w_clamp = w_v[7:0];
    end

    logic r_dstart;
    assign w_div.start = r_dstart;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ccount <= '0;
            r_ocount <= '0;
            o_valid  <= 1'b0;
            r_dstart <= 1'b0;
        end else begin
            r_dstart <= 1'b0;
            if (o_valid && !i_stall && r_state != S_OUT) o_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        case (t_mode'(i_mode))
                            MODE_APPEND_COLOR:
                                if (w_cwe) r_ccount <= r_ccount + 1'b1;
                            MODE_APPEND_OPACITY:
                                if (w_owe) r_ocount <= r_ocount + 1'b1;
                            MODE_CLEAR: begin
                                r_ccount <= '0;
                                r_ocount <= '0;
                            end
                            default: begin
                                r_idx   <= i_sample_index;
                                r_t     <= PW'({i_sample_index, 16'd0});
                                r_tab   <= 1'b0;
                                r_ptr   <= '0;
                                r_left  <= '0;
                                r_state <= S_READ;
                            end
                        endcase
                    end
                end
                S_READ: begin
                    if (w_cnt == '0) begin
                        r_res[r_tab ? 2'd3 : 2'd0] <= '0;
                        r_res[1] <= r_tab ? r_res[1] : 8'd0;
                        r_res[2] <= r_tab ? r_res[2] : 8'd0;
                        r_state <= S_SPAN;
                        r_beyond <= 1'b1;
                        r_vl <= '0;
                    end else begin
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    // data at r_ptr is valid
                    if (r_ptr == '0) begin
                        r_pl <= w_rpos;
                        r_vl <= w_rval;
                        if (w_cnt == CW'(1)) begin
                            r_beyond <= 1'b1;
                            r_state  <= S_SPAN;
                        end else begin
                            r_ptr   <= AW'(1);
                            r_state <= S_READ;
                        end
                    end else begin
                        r_pr <= w_rpos;
                        r_vr <= w_rval;
                        if (CW'(r_ptr) < w_cnt - 1'b1 && r_t > w_rpos_s) begin
                            r_pl  <= w_rpos;
                            r_vl  <= w_rval;
                            r_ptr <= r_ptr + 1'b1;
                            r_state <= S_READ;
                        end else begin
                            r_beyond <= r_t > w_rpos_s;
                            if (r_t > w_rpos_s) r_vl <= w_rval;
                            r_state <= S_SPAN;
                        end
                    end
                end
                S_SPAN: begin
                    if (w_cnt == '0 || r_beyond || r_pl == r_pr) begin
                        if (r_tab) r_res[3] <= r_vl[7:0];
                        else begin
                            r_res[0] <= r_vl[23:16];
                            r_res[1] <= r_vl[15:8];
                            r_res[2] <= r_vl[7:0];
                        end
                        if (r_tab) r_state <= S_OUT;
                        else begin
                            r_tab <= 1'b1; r_ptr <= '0; r_state <= S_READ;
                        end
                    end else begin
                        r_ch    <= r_tab ? 2'd2 : 2'd0;
                        r_state <= S_CHAN;
                    end
                end
                S_CHAN: begin
                    r_prod   <= NW'(w_adv) * NW'(w_adt);
                    r_neg    <= w_sgn;
                    r_vlc    <= w_cvl;
                    r_dstart <= 1'b1;
                    r_state  <= S_DIV;
                end
                S_DIV: begin
                    if (w_div.done) begin
                        if (r_tab) begin
                            r_res[3] <= w_clamp;
                            r_state  <= S_OUT;
                        end else begin
                            r_res[r_ch] <= w_clamp;
                            if (r_ch == 2'd2) begin
                                r_tab <= 1'b1; r_ptr <= '0; r_state <= S_READ;
                            end else begin
                                r_ch <= r_ch + 1'b1;
                                r_state <= S_CHAN;
                            end
                        end
                    end
                end
                S_OUT: begin
                    if (!o_valid || !i_stall) begin
                        o_valid       <= 1'b1;
                        o_texel_index <= r_idx;
                        o_red_out     <= r_res[0];
                        o_green_out   <= r_res[1];
                        o_blue_out    <= r_res[2];
                        o_alpha_out   <= r_res[3];
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    logic w_unused;
    assign w_unused = w_div.busy;

endmodule
`default_nettype wire

FILE: dv/tb_transfer_function_lut_interp_top.sv
`default_nettype none
module tb_transfer_function_lut_interp_top;
    import tfli_pkg::*;

    localparam int NSTOPS   = 16;
    localparam int NSAMPLES = 256;
    localparam int LIMIT    = 2000000;

    typedef struct packed {
        logic [7:0] idx;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
    } t_texel;

    class texel_scoreboard;
        logic [15:0] cpos[NSTOPS];
        logic [23:0] cval[NSTOPS];
        int          ccnt;
        logic [15:0] apos[NSTOPS];
        logic [7:0]  aval[NSTOPS];
        int          acnt;
        t_texel      pending[$];
        int          errors;

        function new();
            ccnt = 0;
            acnt = 0;
            errors = 0;
        endfunction

        function int lerp(longint t, longint pl, longint pr, longint vl, longint vr);
            longint den, num, q, v;
            den = pr - pl;
            if (den == 0) return int'(vl);
            num = (vr - vl) * (t - pl);
            if (den < 0) begin
                den = -den;
                num = -num;
            end
            q = num / den;
            if ((num % den) != 0 && num < 0) q = q - 1;
            v = vl + q;
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            return int'(v);
        endfunction

        function int span_of(bit colour, int n, longint t, output bit beyond);
            int lft, rgt;
            longint p;
            lft = 0;
            rgt = 1;
            forever begin
                p = colour ? longint'(cpos[rgt]) : longint'(apos[rgt]);
                if (!(rgt < n - 1 && t > p * NSAMPLES)) break;
                lft++;
                rgt++;
            end
            p = colour ? longint'(cpos[rgt]) : longint'(apos[rgt]);
            beyond = t > p * NSAMPLES;
            return lft;
        endfunction

        function void note_input(t_mode m, logic [15:0] pos, logic [7:0] r, logic [7:0] g,
                                 logic [7:0] b, logic [7:0] op, logic [7:0] idx);
            t_texel e;
            longint t;
            bit bey;
            int l;
            logic [23:0] vl, vr;
            case (m)
                MODE_APPEND_COLOR: begin
                    if (ccnt < NSTOPS) begin
                        cpos[ccnt] = pos;
                        cval[ccnt] = {r, g, b};
                        ccnt++;
                    end
                end
                MODE_APPEND_OPACITY: begin
                    if (acnt < NSTOPS) begin
                        apos[acnt] = pos;
                        aval[acnt] = op;
                        acnt++;
                    end
                end
                MODE_CLEAR: begin
                    ccnt = 0;
                    acnt = 0;
                end
                default: begin
                    e = '0;
                    e.idx = idx;
                    t = longint'(idx) * 65536;
                    if (ccnt == 1) begin
                        {e.r, e.g, e.b} = cval[0];
                    end else if (ccnt > 1) begin
                        l = span_of(1'b1, ccnt, t, bey);
                        if (bey) begin
                            {e.r, e.g, e.b} = cval[ccnt-1];
                        end else begin
                            vl = cval[l];
                            vr = cval[l+1];
                            e.r = 8'(lerp(t, cpos[l] * NSAMPLES, cpos[l+1] * NSAMPLES,
                                          vl[23:16], vr[23:16]));
                            e.g = 8'(lerp(t, cpos[l] * NSAMPLES, cpos[l+1] * NSAMPLES,
                                          vl[15:8], vr[15:8]));
                            e.b = 8'(lerp(t, cpos[l] * NSAMPLES, cpos[l+1] * NSAMPLES,
                                          vl[7:0], vr[7:0]));
                        end
                    end
                    if (acnt == 1) begin
                        e.a = aval[0];
                    end else if (acnt > 1) begin
                        l = span_of(1'b0, acnt, t, bey);
                        if (bey) e.a = aval[acnt-1];
                        else e.a = 8'(lerp(t, apos[l] * NSAMPLES, apos[l+1] * NSAMPLES,
                                           aval[l], aval[l+1]));
                    end
                    pending = {pending, e};
                end
            endcase
        endfunction

        function void check_result(t_texel got);
            t_texel e;
            if (pending.size() == 0) begin
                $error("unexpected result transaction idx=%0d", got.idx);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.idx !== e.idx) begin
                $error("texel_index exp %0d got %0d", e.idx, got.idx); errors++;
            end
            if (got.r !== e.r) begin
                $error("red_out exp %0d got %0d", e.r, got.r); errors++;
            end
            if (got.g !== e.g) begin
                $error("green_out exp %0d got %0d", e.g, got.g); errors++;
            end
            if (got.b !== e.b) begin
                $error("blue_out exp %0d got %0d", e.b, got.b); errors++;
            end
            if (got.a !== e.a) begin
                $error("alpha_out exp %0d got %0d", e.a, got.a); errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_mode = '0;
    logic [15:0] i_stop_position = '0;
    logic [7:0]  i_stop_red = '0, i_stop_green = '0, i_stop_blue = '0;
    logic [7:0]  i_stop_opacity = '0, i_sample_index = '0;
    logic        o_valid;
    logic        i_stall = 1'b1;
    logic [7:0]  o_texel_index, o_red_out, o_green_out, o_blue_out, o_alpha_out;

    texel_scoreboard sb = new();
    int cycles = 0;

    always #5 i_clk = ~i_clk;

    transfer_function_lut_interp_top dut (.*);

    function automatic int gap_len();
        if ($urandom_range(0, 9) < 7) return $urandom_range(0, 2);
        return $urandom_range(3, 40);
    endfunction

    task automatic send(t_mode m, logic [15:0] pos, logic [7:0] r, logic [7:0] g,
                        logic [7:0] b, logic [7:0] op, logic [7:0] idx, bit idle_ok);
        int n;
        n = idle_ok ? gap_len() : 0;
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode <= m;
        i_stop_position <= pos;
        i_stop_red <= r;
        i_stop_green <= g;
        i_stop_blue <= b;
        i_stop_opacity <= op;
        i_sample_index <= idx;
        do @(posedge i_clk); while (o_stall);
        sb.note_input(m, pos, r, g, b, op, idx);
    endtask

    task automatic rand_item(t_mode m, bit idle_ok);
        send(m, 16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
             8'($urandom), idle_ok);
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb_transfer_function_lut_interp_top: FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result({o_texel_index, o_red_out, o_green_out, o_blue_out, o_alpha_out});
    end

    initial begin : stall_gen
        int n;
        @(posedge i_clk);
        forever begin
            i_stall <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            n = gap_len();
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
        end
    end

    initial begin : stim
        int k, n, mix;
        logic [15:0] p;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send(MODE_EVALUATE, 16'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'd0, 1'b0);
        send(MODE_APPEND_COLOR, 16'h8000, 8'hff, 8'h00, 8'h80, 8'h00, 8'd0, 1'b0);
        send(MODE_APPEND_OPACITY, 16'h4000, 8'h00, 8'h00, 8'h00, 8'hff, 8'd0, 1'b0);
        send(MODE_EVALUATE, 16'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'd255, 1'b0);
        send(MODE_APPEND_COLOR, 16'hffff, 8'h00, 8'hff, 8'h7f, 8'hff, 8'd0, 1'b0);
        send(MODE_APPEND_OPACITY, 16'h4000, 8'h00, 8'h00, 8'h00, 8'h00, 8'd0, 1'b0);
        send(MODE_APPEND_OPACITY, 16'h2000, 8'h00, 8'h00, 8'h00, 8'h80, 8'd0, 1'b0);
        send(MODE_EVALUATE, 16'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'd0, 1'b0);
        send(MODE_EVALUATE, 16'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'd64, 1'b0);
        send(MODE_EVALUATE, 16'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'd200, 1'b0);
        send(MODE_EVALUATE, 16'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'd255, 1'b0);
        for (k = 0; k < 16; k++)
            send(MODE_APPEND_COLOR, 16'(k * 4000), 8'($urandom), 8'($urandom), 8'($urandom),
                 8'h00, 8'd0, 1'b1);
        send(MODE_EVALUATE, 16'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'd255, 1'b0);
        send(MODE_CLEAR, 16'hffff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 1'b0);
        send(MODE_EVALUATE, 16'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'd128, 1'b0);
        for (k = 0; k < 630; ) begin
            mix = $urandom_range(0, 9);
            if (mix < 8) begin
                n = $urandom_range(0, 18);
                p = 16'($urandom_range(0, 3000));
                for (int j = 0; j < n; j++) begin
                    if ($urandom_range(0, 7) == 0) p = 16'($urandom);
                    else p = (p > 16'd61000) ? p : p + 16'($urandom_range(0, 5000));
                    send(MODE_APPEND_COLOR, p, 8'($urandom), 8'($urandom), 8'($urandom),
                         8'($urandom), 8'($urandom), 1'b1);
                    k++;
                end
                n = $urandom_range(0, 18);
                p = 16'($urandom_range(0, 3000));
                for (int j = 0; j < n; j++) begin
                    if ($urandom_range(0, 7) == 0) p = 16'($urandom);
                    else p = (p > 16'd61000) ? p : p + 16'($urandom_range(0, 5000));
                    send(MODE_APPEND_OPACITY, p, 8'($urandom), 8'($urandom), 8'($urandom),
                         8'($urandom), 8'($urandom), 1'b1);
                    k++;
                end
                n = $urandom_range(2, 10);
                for (int j = 0; j < n; j++) begin
                    rand_item(MODE_EVALUATE, 1'b1);
                    k++;
                end
                rand_item(MODE_CLEAR, 1'b1);
                k++;
            end else begin
                rand_item(t_mode'($urandom_range(0, 3)), 1'b1);
                k++;
            end
        end
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("tb_transfer_function_lut_interp_top: PASS");
        end else begin
            $display("tb_transfer_function_lut_interp_top: FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire

FILE: sim.f
rtl/tfli_pkg.sv
rtl/tfli_ram.sv
rtl/tfli_div.sv
rtl/transfer_function_lut_interp_top.sv
dv/tb_transfer_function_lut_interp_top.sv
